[hdl/bed_pkg.sv]
`default_nettype none

package bed_pkg;

    // Widths of the button masks and of the time base
    localparam int BTN_W  = 10;
    localparam int TIME_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SUB   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SUB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HELD_SUB    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SUB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DTAP_SUB    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd5;

    // 300 ms window after reset
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd300000;

    // Per-button controls from the top level to one lane
    typedef struct packed {
        logic adv;      // item in the input register moves to the result register
        logic level;    // button is down this tick
        logic down;     // button went down this tick
        logic rep_sub;  // auto-repeat enabled
        logic dtap_sub; // double-tap enabled
    } lane_ctl_t;

    // Per-button events back from a lane
    typedef struct packed {
        logic rep;
        logic dtap;
    } lane_ev_t;

endpackage

`default_nettype wire

[hdl/bed_if.sv]
`default_nettype none

// Tick channel: button levels and time
interface bed_in_if import bed_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BTN_W-1:0]  buttons_now;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output buttons_now, output time_us, input ready);
    modport sink   (input valid, input buttons_now, input time_us, output ready);
endinterface

// Event channel: five event masks
interface bed_out_if import bed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] pressed_events;
    logic [BTN_W-1:0] released_events;
    logic [BTN_W-1:0] held_events;
    logic [BTN_W-1:0] repeat_events;
    logic [BTN_W-1:0] double_tap_events;

    modport source (output valid, output pressed_events, output released_events,
                    output held_events, output repeat_events,
                    output double_tap_events, input ready);
    modport sink   (input valid, input pressed_events, input released_events,
                    input held_events, input repeat_events,
                    input double_tap_events, output ready);
endinterface

`default_nettype wire

[hdl/bed_lane.sv]
`default_nettype none

// One button: shared stamp, tap flag, repeat and double-tap decisions.
module bed_lane import bed_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lane_ctl_t         ctl,
    input  wire logic [TIME_W-1:0] time_us,
    input  wire logic [TIME_W-1:0] interval_us,
    output lane_ev_t               ev
);

    logic [TIME_W-1:0] stamp_reg, stamp_next;
    logic              tap_reg, tap_next;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] dtap_diff;
    logic              rep;
    logic              dtap_en;
    logic              dtap_hit;

    // Repeat restamps to now, so the double-tap check then sees a zero gap
    assign diff      = time_us - stamp_reg;
    assign rep       = ctl.rep_sub && ctl.level && (diff > interval_us);
    assign dtap_diff = rep ? '0 : diff;
    assign dtap_en   = ctl.dtap_sub && ctl.down;
    assign dtap_hit  = tap_reg && (dtap_diff < interval_us);

    assign ev.rep  = rep;
    assign ev.dtap = dtap_en && dtap_hit;

    always_comb
    begin
        stamp_next = stamp_reg;
        tap_next   = tap_reg;
        if (rep)
        begin
            stamp_next = time_us;
        end
        if (dtap_en)
        begin
            tap_next = !dtap_hit;
            if (!dtap_hit)
            begin
                stamp_next = time_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            tap_reg   <= 1'b0;
        end
        else if (ctl.adv)
        begin
            stamp_reg <= stamp_next;
            tap_reg   <= tap_next;
        end
    end

`ifndef ASSERT_OFF
    a_rep_restamps: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.adv && ev.rep |=> stamp_reg == $past(time_us))
        else $error("repeat did not restamp");

    a_dtap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.adv && ev.dtap |=> !tap_reg)
        else $error("double tap left tap flag set");

    a_dtap_needs_tap: assert property (@(posedge clk) disable iff (!rst_n)
        ev.dtap |-> tap_reg && ctl.down)
        else $error("double tap without first tap");
`endif

endmodule

`default_nettype wire

[hdl/button_event_detector_core.sv]
`default_nettype none

// Button event detector: press / release / held / auto-repeat / double-tap masks.
// A transferred tick waits in the input register; its events go to the result
// register when free and stay until taken; buttons are handled in parallel lanes.
// Throughput: one tick per cycle while result.ready is high.
// Reset (rst_n, async, active low): subscriptions cleared, interval 300000 us,
// previous levels, stamps and tap flags cleared, both stages empty.
module button_event_detector_core import bed_pkg::*;
#(
    parameter int NUM_BUTTONS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bed_in_if.sink                     item,
    bed_out_if.source                  result,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    // Buttons past the mask width never exist on the ports
    localparam int LANES = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
    localparam logic [BTN_W-1:0] LANE_MASK = {BTN_W{1'b1}} >> (BTN_W - LANES);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [BTN_W-1:0]  press_sub_reg;
    logic [BTN_W-1:0]  release_sub_reg;
    logic [BTN_W-1:0]  held_sub_reg;
    logic [BTN_W-1:0]  repeat_sub_reg;
    logic [BTN_W-1:0]  dtap_sub_reg;
    logic [TIME_W-1:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_sub_reg   <= '0;
            release_sub_reg <= '0;
            held_sub_reg    <= '0;
            repeat_sub_reg  <= '0;
            dtap_sub_reg    <= '0;
            interval_reg    <= INTERVAL_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PRESS_SUB:   press_sub_reg   <= wr_data[BTN_W-1:0];
                REG_RELEASE_SUB: release_sub_reg <= wr_data[BTN_W-1:0];
                REG_HELD_SUB:    held_sub_reg    <= wr_data[BTN_W-1:0];
                REG_REPEAT_SUB:  repeat_sub_reg  <= wr_data[BTN_W-1:0];
                REG_DTAP_SUB:    dtap_sub_reg    <= wr_data[BTN_W-1:0];
                REG_INTERVAL:    interval_reg    <= wr_data[TIME_W-1:0];
                default:         ; // unknown index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic              s1_valid_reg;
    logic [BTN_W-1:0]  s1_now_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic              adv;      // input register moves into the result register
    logic              take;     // tick transfer on the input channel

    // Result register frees up when empty or when its transfer happens now
    assign adv        = s1_valid_reg && (!result.valid || result.ready);
    assign item.ready = !s1_valid_reg || adv;
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_now_reg  <= item.buttons_now & LANE_MASK;
            s1_time_reg <= item.time_us;
        end
    end

    // ---------------------------------------------------------------
    // Edge detection against the levels of the previous tick
    // ---------------------------------------------------------------
    logic [BTN_W-1:0] prev_reg;
    logic [BTN_W-1:0] down;
    logic [BTN_W-1:0] up;
    logic [BTN_W-1:0] rep_vec;
    logic [BTN_W-1:0] dtap_vec;

    assign down = s1_now_reg & ~prev_reg;
    assign up   = ~s1_now_reg & prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (adv)
        begin
            prev_reg <= s1_now_reg;
        end
    end

    // ---------------------------------------------------------------
    // Per-button lanes (stamp and tap flag live there)
    // ---------------------------------------------------------------
    for (genvar i = 0; i < BTN_W; i++)
    begin : g_lane
        if (i < LANES)
        begin : g_used
            lane_ctl_t ctl;
            lane_ev_t  ev;

            assign ctl.adv      = adv;
            assign ctl.level    = s1_now_reg[i];
            assign ctl.down     = down[i];
            assign ctl.rep_sub  = repeat_sub_reg[i];
            assign ctl.dtap_sub = dtap_sub_reg[i];

            bed_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .time_us     (s1_time_reg),
                .interval_us (interval_reg),
                .ev          (ev)
            );

            assign rep_vec[i]  = ev.rep;
            assign dtap_vec[i] = ev.dtap;
        end
        else
        begin : g_none
            assign rep_vec[i]  = 1'b0;
            assign dtap_vec[i] = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic             out_valid_reg;
    logic [BTN_W-1:0] pressed_reg;
    logic [BTN_W-1:0] released_reg;
    logic [BTN_W-1:0] held_reg;
    logic [BTN_W-1:0] repeat_reg;
    logic [BTN_W-1:0] dtap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pressed_reg  <= down & press_sub_reg;
            released_reg <= up & release_sub_reg;
            held_reg     <= s1_now_reg & held_sub_reg;
            repeat_reg   <= rep_vec;
            dtap_reg     <= dtap_vec;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.pressed_events    = pressed_reg;
    assign result.released_events   = released_reg;
    assign result.held_events       = held_reg;
    assign result.repeat_events     = repeat_reg;
    assign result.double_tap_events = dtap_reg;

`ifndef ASSERT_OFF
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !s1_valid_reg |=> !result.valid)
        else $error("result repeated after its transfer");

    a_rep_subscribed: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> (rep_vec & ~(repeat_sub_reg & s1_now_reg)) == '0)
        else $error("repeat on a button that is not held and subscribed");

    a_dtap_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> (dtap_vec & ~(dtap_sub_reg & down)) == '0)
        else $error("double tap without a subscribed press");
`endif

endmodule

`default_nettype wire

[tb/sv/button_event_detector_core_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for button_event_detector_core.
// Ticks go in on the item channel and their predicted event masks are queued.
// A monitor compares every result transfer against the oldest queued masks.
// Both channels idle at random, with some phases that run back to back.
module button_event_detector_core_test;
    import bed_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;      // pipeline is two stages deep
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_TICKS   = 150;
    localparam int BTN_IDX_W     = $clog2(BTN_W);

    // Indexes that decode to no register; writes there must not disturb anything
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [BTN_W-1:0]  ALL_BUTTONS = '1;
    localparam logic [BTN_W-1:0]  NO_BUTTONS  = '0;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;

    typedef struct packed {
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] released;
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] rep;
        logic [BTN_W-1:0] dtap;
    } events_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    bed_in_if  tick_ch ();
    bed_out_if event_ch ();

    button_event_detector_core #(
        .NUM_BUTTONS (BTN_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (tick_ch),
        .result   (event_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the detector: subscriptions, window and per-button
    // state. Per-button state follows each tick transfer, the rest each write.
    // ------------------------------------------------------------------
    logic [BTN_W-1:0]  sub_press;
    logic [BTN_W-1:0]  sub_release;
    logic [BTN_W-1:0]  sub_held;
    logic [BTN_W-1:0]  sub_repeat;
    logic [BTN_W-1:0]  sub_dtap;
    logic [TIME_W-1:0] window_us;

    logic [BTN_W-1:0]  last_levels;
    logic [TIME_W-1:0] stamp_us [BTN_W];
    logic [BTN_W-1:0]  tap_armed;

    events_t expected_events [$];
    int      mismatch_count;
    int      cycle_count;
    int      stall_left;
    bit      steady;             // no idling on either side while set

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One tick of the detector. Repeat is evaluated first, so a press on a
    // repeat button can restamp it before the double-tap compare looks at
    // the stamp. Ages are unsigned 32-bit differences, so they wrap.
    function automatic events_t predict_events(input logic [BTN_W-1:0]  levels,
                                               input logic [TIME_W-1:0] now_us);
        events_t           ev;
        logic [BTN_W-1:0]  went_down;
        logic [BTN_W-1:0]  went_up;
        logic [TIME_W-1:0] age;
        ev        = '0;
        went_down = levels & ~last_levels;
        went_up   = ~levels & last_levels;
        for (int b = 0; b < BTN_W; b++)
        begin
            if (sub_repeat[b] && levels[b])
            begin
                age = now_us - stamp_us[b];
                // strictly past the window
                if (age > window_us)
                begin
                    ev.rep[b]   = 1'b1;
                    stamp_us[b] = now_us;
                end
            end
        end
        for (int b = 0; b < BTN_W; b++)
        begin
            if (sub_dtap[b] && went_down[b])
            begin
                age = now_us - stamp_us[b];
                // second tap must land strictly inside the window
                if (tap_armed[b] && age < window_us)
                begin
                    ev.dtap[b]   = 1'b1;
                    tap_armed[b] = 1'b0;
                end
                else
                begin
                    // missed or first tap: arm and restamp
                    tap_armed[b] = 1'b1;
                    stamp_us[b]  = now_us;
                end
            end
        end
        ev.pressed  = went_down & sub_press;
        ev.released = went_up & sub_release;
        ev.held     = levels & sub_held;
        last_levels = levels;
        return ev;
    endfunction

    // Register write. Only issued while the pipeline is empty, so the shadow
    // copy can follow right away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PRESS_SUB:   sub_press   = data[BTN_W-1:0];
            REG_RELEASE_SUB: sub_release = data[BTN_W-1:0];
            REG_HELD_SUB:    sub_held    = data[BTN_W-1:0];
            REG_REPEAT_SUB:  sub_repeat  = data[BTN_W-1:0];
            REG_DTAP_SUB:    sub_dtap    = data[BTN_W-1:0];
            REG_INTERVAL:    window_us   = data[TIME_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic write_all(input logic [BTN_W-1:0]  subs,
                             input logic [TIME_W-1:0] window);
        write_reg(REG_PRESS_SUB, CFG_DATA_W'(subs));
        write_reg(REG_RELEASE_SUB, CFG_DATA_W'(subs));
        write_reg(REG_HELD_SUB, CFG_DATA_W'(subs));
        write_reg(REG_REPEAT_SUB, CFG_DATA_W'(subs));
        write_reg(REG_DTAP_SUB, CFG_DATA_W'(subs));
        write_reg(REG_INTERVAL, window);
    endtask

    // Present one tick, hold it until transferred, then queue its events.
    // valid stays high into the next tick unless a gap is drawn.
    task automatic send_tick(input logic [BTN_W-1:0]  levels,
                             input logic [TIME_W-1:0] now_us);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.buttons_now <= levels;
        tick_ch.time_us     <= now_us;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        expected_events.push_back(predict_events(levels, now_us));
    endtask

    // Stop sending and wait for every queued result, then let the pipe settle
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(input string field, input logic [BTN_W-1:0] want,
                                input logic [BTN_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h got %h", $realtime, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, compare each transfer with the oldest
    // queued prediction. ready is sampled before this edge's updates.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        events_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end
            else
            begin
                want = expected_events.pop_front();
                report_field("pressed_events", want.pressed, event_ch.pressed_events);
                report_field("released_events", want.released, event_ch.released_events);
                report_field("held_events", want.held, event_ch.held_events);
                report_field("repeat_events", want.rep, event_ch.repeat_events);
                report_field("double_tap_events", want.dtap, event_ch.double_tap_events);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            event_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            event_ch.ready <= (stall_left == 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("button_event_detector_core_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: nothing subscribed, then everything subscribed with the
    // window left at its reset value. The age check at 300000 vs 300001
    // only passes if the window came out of reset right.
    task automatic test_reset_values();
        send_tick(ALL_BUTTONS, 32'd10);
        send_tick(NO_BUTTONS, 32'd20);
        drain();
        write_reg(REG_PRESS_SUB, CFG_DATA_W'(ALL_BUTTONS));
        write_reg(REG_RELEASE_SUB, CFG_DATA_W'(ALL_BUTTONS));
        write_reg(REG_HELD_SUB, CFG_DATA_W'(ALL_BUTTONS));
        write_reg(REG_REPEAT_SUB, CFG_DATA_W'(ALL_BUTTONS));
        write_reg(REG_DTAP_SUB, CFG_DATA_W'(ALL_BUTTONS));
        send_tick(ALL_BUTTONS, 32'd100);
        send_tick(ALL_BUTTONS, 32'd300100);
        send_tick(ALL_BUTTONS, 32'd300101);
        drain();
    endtask

    // Window edges with a 100 us window: an age of exactly 100 is no repeat,
    // 99 taps, 200 repeats. Then a double tap across the wrap.
    task automatic test_window_edges();
        write_all(ALL_BUTTONS, 32'd100);
        send_tick(NO_BUTTONS, 32'd1000);
        send_tick(ALL_BUTTONS, 32'd1100);
        send_tick(NO_BUTTONS, 32'd1150);
        send_tick(ALL_BUTTONS, 32'd1200);
        send_tick(NO_BUTTONS, 32'd1250);
        send_tick(ALL_BUTTONS, 32'd1299);
        send_tick(ALL_BUTTONS, 32'd1400);
        send_tick(ALL_BUTTONS, 32'd1500);
        send_tick(NO_BUTTONS, 32'hFFFF_FFC0);
        send_tick(10'h155, 32'hFFFF_FFE0);
        send_tick(NO_BUTTONS, 32'hFFFF_FFF0);
        send_tick(10'h2AA | 10'h155, 32'h0000_0010);
        drain();
    endtask

    // Zero window: repeat on any age above zero, never a double tap.
    // All-ones window: never a repeat, almost any second press taps.
    task automatic test_window_extremes();
        write_reg(REG_INTERVAL, '0);
        send_tick(ALL_BUTTONS, 32'd0);
        send_tick(ALL_BUTTONS, 32'd0);
        send_tick(NO_BUTTONS, TIME_MAX);
        send_tick(ALL_BUTTONS, 32'd0);
        drain();
        write_reg(REG_INTERVAL, TIME_MAX);
        send_tick(ALL_BUTTONS, 32'h8000_0000);
        send_tick(NO_BUTTONS, 32'h8000_0001);
        send_tick(ALL_BUTTONS, 32'h7FFF_FFFF);
        drain();
    endtask

    // Upper data bits of the subscription writes are dropped, and writes to
    // indexes without a register change nothing.
    task automatic test_register_decode();
        write_reg(REG_PRESS_SUB, 32'hFFFF_FC00 | 32'h0AB);
        write_reg(REG_RELEASE_SUB, 32'hA5A5_A800 | 32'h354);
        write_reg(REG_HELD_SUB, 32'h5A5A_5400 | 32'h0F0);
        write_reg(REG_REPEAT_SUB, 32'hFFFF_FC00 | 32'h30F);
        write_reg(REG_DTAP_SUB, 32'hFFFF_FC00 | 32'h1C3);
        write_reg(REG_INTERVAL, 32'd50);
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        send_tick(NO_BUTTONS, 32'd5000);
        send_tick(ALL_BUTTONS, 32'd5100);
        send_tick(NO_BUTTONS, 32'd5120);
        send_tick(ALL_BUTTONS, 32'd5140);
        drain();
    endtask

    // Random phases. Most ticks move time forward by steps picked around the
    // window and toggle a few buttons, so taps and repeats line up with the
    // window edges; the rest are noise with arbitrary levels and time.
    task automatic test_random_sequences();
        logic [BTN_W-1:0]  levels;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] window;
        logic [TIME_W-1:0] step_us;
        logic [BTN_W-1:0]  subs;
        levels = NO_BUTTONS;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       window = INTERVAL_RESET;
                1:       window = '0;
                2:       window = TIME_MAX;
                3:       window = 32'd1;
                default: window = ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(2, 2000);
            endcase
            if (phase == 0)
                subs = ALL_BUTTONS;
            else if (phase == 5)
                subs = NO_BUTTONS;
            else
                subs = BTN_W'($urandom);
            write_reg(REG_PRESS_SUB, ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(subs) : $urandom);
            write_reg(REG_RELEASE_SUB, $urandom | CFG_DATA_W'(subs));
            write_reg(REG_HELD_SUB, $urandom);
            write_reg(REG_REPEAT_SUB, CFG_DATA_W'(subs));
            write_reg(REG_DTAP_SUB, (phase == 0) ? CFG_DATA_W'(subs) : CFG_DATA_W'(subs) | $urandom);
            write_reg(REG_INTERVAL, window);
            steady = (phase % 4 == 3);
            now_us = $urandom;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    case ($urandom_range(0, 9))
                        0:       step_us = '0;
                        1:       step_us = window - 32'd1;
                        2:       step_us = window;
                        3:       step_us = window + 32'd1;
                        7:       step_us = window >> 1;
                        8:       step_us = $urandom;
                        9:       step_us = window + $urandom_range(2, 100);
                        default: step_us = $urandom_range(1, 64);
                    endcase
                    now_us += step_us;
                    if ($urandom_range(0, 1) != 0)
                        levels ^= BTN_W'($urandom & $urandom & $urandom);
                    else
                        levels[BTN_IDX_W'($urandom_range(0, BTN_W - 1))] ^= 1'b1;
                end
                else
                begin
                    levels = BTN_W'($urandom);
                    now_us = $urandom;
                end
                send_tick(levels, now_us);
            end
            // sender holds off here until all events have come back
            drain();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        // everything driven to a known value before the first edge
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = REG_PRESS_SUB;
        wr_data             = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.buttons_now = '0;
        tick_ch.time_us     = '0;
        event_ch.ready      = 1'b0;
        mismatch_count      = 0;
        cycle_count         = 0;
        stall_left          = 0;
        steady              = 1'b0;

        // shadow state after reset
        sub_press   = '0;
        sub_release = '0;
        sub_held    = '0;
        sub_repeat  = '0;
        sub_dtap    = '0;
        window_us   = INTERVAL_RESET;
        last_levels = '0;
        tap_armed   = '0;
        for (int b = 0; b < BTN_W; b++)
            stamp_us[b] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_window_edges();
        test_window_extremes();
        test_register_decode();
        test_random_sequences();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("button_event_detector_core_test: clean");
        else
            $display("button_event_detector_core_test: errors");
        $finish;
    end

endmodule

[button_event_detector_core.f]
hdl/bed_pkg.sv
hdl/bed_if.sv
hdl/bed_lane.sv
hdl/button_event_detector_core.sv
tb/sv/button_event_detector_core_test.sv
